/* sv/src_pkg.sv */
// package for the source route cache: widths, kinds and status codes
package src_pkg;
    localparam int ADDR_W = 16;
    localparam int DEF_ENTRIES = 8;
    localparam int DEF_MAX_HOPS = 8;
    localparam int STAGE_DEPTH = 8;
    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_FWD = 3'd1;
    localparam logic [2:0] KIND_REV = 3'd2;
    localparam logic [2:0] KIND_LOOKUP = 3'd3;
    localparam logic [2:0] KIND_EXPIRE = 3'd4;
    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_OLDEST = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_SKIP = 3'd4;
    localparam logic [2:0] ST_BADLEN = 3'd5;
    localparam logic [2:0] ST_LOOKUP = 3'd6;
endpackage

/* sv/source_route_cache.sv */
// source route cache top level: entry scan, hop-list memory and result stream
//
// channel | direction | handshake           | payload
// s_      | in        | s_valid / s_ready   | kind, slot_index, node_addr, target_addr, ...
// m_      | out       | m_valid / m_ready   | status, found, entry_index, hop_count, ...
// cfg     | in        | cfg_wr_en           | cfg_wr_data (own node address)
//
// one word at a time. load and expire need no further state. an insert scans the
// entries: each compared hop needs a memory read and then a compare, then the
// slot is picked and one hop is written a cycle.
// a lookup scans every entry, then reads out the best match's hops one at a time.
// reset clears the entry table at once; the hop memory needs no clearing.
// a stalled result holds the block until it is taken.
module source_route_cache #(
    parameter int ENTRIES  = src_pkg::DEF_ENTRIES,
    parameter int MAX_HOPS = src_pkg::DEF_MAX_HOPS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [src_pkg::ADDR_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_kind,
    input  logic [2:0]               s_slot_index,
    input  logic [src_pkg::ADDR_W-1:0] s_node_addr,
    input  logic [src_pkg::ADDR_W-1:0] s_target_addr,
    input  logic [3:0]               s_route_hops,
    input  logic [3:0]               s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic                     m_found,
    output logic [2:0]               m_entry_index,
    output logic [3:0]               m_hop_count,
    output logic [src_pkg::ADDR_W-1:0] m_hop_addr,
    output logic                     m_last
);
    import src_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HW = $clog2(MAX_HOPS);
    localparam int MW = EW + HW;
    localparam int SW = $clog2(STAGE_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // entry header check
    localparam logic [3:0] S_CMP   = 4'd2;  // hop compare against the registered memory read
    localparam logic [3:0] S_STORE = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_LSCAN = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LOUT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // control and table state
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] own_reg;
    logic [ADDR_W-1:0] dest_reg [ENTRIES];
    logic [3:0]        hops_reg [ENTRIES];
    logic [ENTRIES-1:0] exp_reg;
    logic [EW-1:0]     oldest_reg, fill_reg;
    logic              full_reg;
    logic [ADDR_W-1:0] stage_reg [STAGE_DEPTH];

    // working item
    logic              rev_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        pos_reg;
    logic [EW:0]       ent_reg;
    logic [4:0]        hop_reg;
    logic              best_ok_reg;
    logic [EW-1:0]     best_reg;
    logic [3:0]        bhops_reg;

    // hop memory
    logic [ADDR_W-1:0] mem [ENTRIES << HW];
    logic [ADDR_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [MW-1:0]     mem_wa, mem_ra;
    logic [ADDR_W-1:0] mem_wd;

    // output register
    logic              ov_reg;
    logic [2:0]        ost_reg;
    logic              ofnd_reg;
    logic [2:0]        oidx_reg;
    logic [3:0]        ohc_reg;
    logic [ADDR_W-1:0] oaddr_reg;
    logic              olast_reg;

    assign s_ready = (state_reg == S_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_status = ost_reg;
    assign m_found = ofnd_reg;
    assign m_entry_index = oidx_reg;
    assign m_hop_count = ohc_reg;
    assign m_hop_addr = oaddr_reg;
    assign m_last = olast_reg;

    // staged route word k of the working item
    function automatic logic [ADDR_W-1:0] route_word(input logic [4:0] k,
            input logic rev, input logic [ADDR_W-1:0] own,
            input logic [ADDR_W-1:0] stk_f, input logic [ADDR_W-1:0] stk_r);
        logic [ADDR_W-1:0] w;
        begin
            if (rev) w = (k == 5'd0) ? own : stk_r;
            else     w = stk_f;
            route_word = w;
        end
    endfunction

    logic [SW-1:0]     fidx, ridx;
    logic [ADDR_W-1:0] rword;
    logic [EW-1:0]     ent_i;
    logic [HW-1:0]     hop_i;
    logic              ent_hit;
    logic [EW-1:0]     low_exp;
    logic              any_exp;

    always_comb begin
        fidx  = SW'(pos_reg + 4'(hop_reg));
        ridx  = SW'(pos_reg - 4'(hop_reg));
        rword = route_word(hop_reg, rev_reg, own_reg, stage_reg[fidx], stage_reg[ridx]);
        ent_i = ent_reg[EW-1:0];
        hop_i = hop_reg[HW-1:0];
        ent_hit = (dest_reg[ent_i] == dst_reg) && !exp_reg[ent_i]
                  && (hops_reg[ent_i] == cnt_reg);
        low_exp = '0;
        any_exp = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (exp_reg[i]) begin
                low_exp = EW'(i);
                any_exp = 1'b1;
            end
        end
    end

    // hop memory read address and write port
    always_comb begin
        mem_ra = MW'({ent_i, hop_i});
        mem_we = (state_reg == S_WR) && (5'(hop_reg) < 5'(cnt_reg));
        mem_wa = MW'({best_reg, hop_i});
        mem_wd = rword;
        if (state_reg == S_LRD || state_reg == S_LOUT) mem_ra = MW'({best_reg, hop_i});
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            own_reg <= '0;
            exp_reg <= '0;
            oldest_reg <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                dest_reg[i] <= '0;
                hops_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) own_reg <= cfg_wr_data;
            // the hop stream reloads the word itself when it is taken
            if (ov_reg && m_ready && state_reg != S_LOUT) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        rev_reg <= (s_kind == KIND_REV);
                        dst_reg <= (s_kind == KIND_REV) ? stage_reg[0] : s_target_addr;
                        ent_reg <= '0;
                        hop_reg <= {4'd0, (s_kind == KIND_REV)};
                        best_ok_reg <= 1'b0;
                        ost_reg <= (s_kind == KIND_REV && s_position == 4'd0) ? ST_SKIP
                                   : ST_BADLEN;
                        ofnd_reg <= 1'b0;
                        oidx_reg <= '0;
                        ohc_reg <= '0;
                        oaddr_reg <= '0;
                        olast_reg <= 1'b1;
                        unique case (s_kind)
                            KIND_LOAD: stage_reg[s_slot_index] <= s_node_addr;
                            KIND_EXPIRE: begin
                                if (32'(s_slot_index) < ENTRIES)
                                    exp_reg[EW'(s_slot_index)] <= 1'b1;
                            end
                            KIND_FWD: begin
                                pos_reg <= s_position;
                                cnt_reg <= s_route_hops - s_position;
                                if (s_position > s_route_hops || s_route_hops > 4'd8
                                    || 32'(s_route_hops - s_position) > MAX_HOPS)
                                    ov_reg <= 1'b1;
                                else state_reg <= S_SCAN;
                            end
                            KIND_REV: begin
                                pos_reg <= s_position;
                                cnt_reg <= s_position;
                                if (s_position == 4'd0) begin
                                    ov_reg <= 1'b1;
                                end else if (s_position > 4'd7
                                             || 32'(s_position) > MAX_HOPS)
                                    ov_reg <= 1'b1;
                                else state_reg <= S_SCAN;
                            end
                            KIND_LOOKUP: state_reg <= S_LSCAN;
                            default: ;
                        endcase
                    end
                end
                // header check, then step hops through memory
                S_SCAN: begin
                    if (32'(ent_reg) >= ENTRIES) begin
                        hop_reg <= '0;
                        state_reg <= S_STORE;
                    end else if (ent_hit && 5'(hop_reg) >= 5'(cnt_reg)) begin
                        ost_reg <= ST_PRESENT;
                        oidx_reg <= 3'(ent_i);
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (ent_hit) begin
                        state_reg <= S_CMP;
                    end else begin
                        ent_reg <= ent_reg + 1'b1;
                        hop_reg <= {4'd0, rev_reg};
                    end
                end
                S_CMP: begin
                    if (rd_data_reg == rword) begin
                        hop_reg <= hop_reg + 5'd1;
                        state_reg <= S_SCAN;
                    end else begin
                        ent_reg <= ent_reg + 1'b1;
                        hop_reg <= {4'd0, rev_reg};
                        state_reg <= S_SCAN;
                    end
                end
                // pick the slot and update pointers
                S_STORE: begin
                    if (!full_reg) begin
                        best_reg <= fill_reg;
                        ost_reg <= ST_FREE;
                        fill_reg <= (32'(fill_reg) == ENTRIES - 1) ? '0 : fill_reg + 1'b1;
                        if (((32'(fill_reg) == ENTRIES - 1) ? '0 : fill_reg + 1'b1)
                            == oldest_reg) full_reg <= 1'b1;
                    end else if (any_exp) begin
                        best_reg <= low_exp;
                        ost_reg <= ST_EXPIRED;
                    end else begin
                        best_reg <= oldest_reg;
                        ost_reg <= ST_OLDEST;
                        oldest_reg <= (32'(oldest_reg) == ENTRIES - 1) ? '0
                                      : oldest_reg + 1'b1;
                    end
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (5'(hop_reg) >= 5'(cnt_reg)) begin
                        dest_reg[best_reg] <= dst_reg;
                        hops_reg[best_reg] <= cnt_reg;
                        exp_reg[best_reg] <= 1'b0;
                        oidx_reg <= 3'(best_reg);
                        ov_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else hop_reg <= hop_reg + 5'd1;
                end
                // lookup: fewest-hop valid match
                S_LSCAN: begin
                    if (32'(ent_reg) >= ENTRIES) begin
                        hop_reg <= '0;
                        ost_reg <= ST_LOOKUP;
                        if (!best_ok_reg) begin
                            ov_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else if (bhops_reg == 4'd0) begin
                            ofnd_reg <= 1'b1;
                            oidx_reg <= 3'(best_reg);
                            ov_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else state_reg <= S_LRD;
                    end else begin
                        if (dest_reg[ent_i] == dst_reg && !exp_reg[ent_i]
                            && (!best_ok_reg || hops_reg[ent_i] < bhops_reg)) begin
                            best_ok_reg <= 1'b1;
                            best_reg <= ent_i;
                            bhops_reg <= hops_reg[ent_i];
                        end
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
                S_LRD: state_reg <= S_LOUT;
                S_LOUT: begin
                    if (!ov_reg || m_ready) begin
                        ov_reg <= 1'b1;
                        ofnd_reg <= 1'b1;
                        oidx_reg <= 3'(best_reg);
                        ohc_reg <= bhops_reg;
                        oaddr_reg <= rd_data_reg;
                        if (hop_reg + 5'd1 >= 5'(bhops_reg)
                            || 32'(hop_reg) + 1 >= MAX_HOPS) begin
                            olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            olast_reg <= 1'b0;
                            hop_reg <= hop_reg + 5'd1;
                            state_reg <= S_LRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
